[rtl/core/modexp_pkg.sv]
// Shared constants for the modular exponentiation block.
// No dependencies; used by modexp_mulmod and modular_exponentiation.
package modexp_pkg;

    localparam int unsigned FieldWidth = 30;
    localparam int unsigned StepWidth  = 5;

    localparam logic [FieldWidth-1:0] Prime      = 30'd1000000007;
    localparam logic [StepWidth-1:0]  LastStep   = StepWidth'(FieldWidth - 1);
    localparam logic [FieldWidth-1:0] One        = 30'd1;

endpackage

[rtl/core/modexp_mulmod.sv]
// Bit-serial modular multiplier: result = a * b mod Prime, one bit of b per cycle.
// Depends on modexp_pkg.
module modexp_mulmod (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [modexp_pkg::FieldWidth-1:0]   a,
    input  logic [modexp_pkg::FieldWidth-1:0]   b,
    output logic                                done,
    output logic [modexp_pkg::FieldWidth-1:0]   result
);

    logic                                running_reg;
    logic                                done_reg;
    logic [modexp_pkg::StepWidth-1:0]    cnt_reg;
    logic [modexp_pkg::FieldWidth-1:0]   a_reg;
    logic [modexp_pkg::FieldWidth-1:0]   b_reg;
    logic [modexp_pkg::FieldWidth-1:0]   r_reg;
    logic [modexp_pkg::FieldWidth-1:0]   r_next;

    logic [modexp_pkg::FieldWidth:0]     dbl;
    logic [modexp_pkg::FieldWidth:0]     dbl_red;
    logic [modexp_pkg::FieldWidth:0]     sum;
    logic [modexp_pkg::FieldWidth:0]     prime_ext;

    // Horner step, MSB first: r = 2r + bit*a, reduced after each add.
    always_comb
    begin
        prime_ext = {1'b0, modexp_pkg::Prime};
        dbl       = {r_reg, 1'b0};
        dbl_red   = (dbl >= prime_ext) ? dbl - prime_ext : dbl;
        sum       = dbl_red + (b_reg[modexp_pkg::FieldWidth-1] ? {1'b0, a_reg} :
                                                              '0);
        r_next    = (sum >= prime_ext) ? modexp_pkg::FieldWidth'(sum - prime_ext) :
                                         modexp_pkg::FieldWidth'(sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                running_reg <= 1'b1;
                cnt_reg     <= modexp_pkg::LastStep;
            end
            else if (running_reg)
            begin
                if (cnt_reg == '0)
                begin
                    running_reg <= 1'b0;
                    done_reg    <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
            r_reg <= '0;
        end
        else if (running_reg)
        begin
            r_reg <= r_next;
            b_reg <= {b_reg[modexp_pkg::FieldWidth-2:0], 1'b0};
        end
    end

    assign done   = done_reg;
    assign result = r_reg;

`ifndef SYNTH
    a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (r_reg < modexp_pkg::Prime))
        else $error("mulmod result not reduced");
    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (running_reg && cnt_reg == modexp_pkg::LastStep))
        else $error("mulmod did not start");
    a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !running_reg)
        else $error("mulmod done while running");
`endif

endmodule

[rtl/core/modular_exponentiation.sv]
// Top level: power = base ^ exponent mod Prime, right-to-left square-and-multiply.
// Depends on modexp_pkg and modexp_mulmod.
//
//   channel   ports                     transfer
//   input     start, base, exponent     start high and busy low at a clock edge
//   output    done, power               done high for one cycle; always taken
//
// For each exponent bit the controller checks the exponent, loads the
// operands, lets both serial multipliers (square and accumulate, run side
// by side) take their 30 bit steps, and then picks up the products.
// The loop runs up to the highest set exponent bit; a zero exponent finishes
// at the first check. rst_n clears control state asynchronously.
// No item is lost to a stall, since the receiver cannot stall. The user must
// hold off the next start while busy is high; the block ignores it then.
module modular_exponentiation (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [modexp_pkg::FieldWidth-1:0]   base,
    input  logic [modexp_pkg::FieldWidth-1:0]   exponent,
    output logic                                busy,
    output logic                                done,
    output logic [modexp_pkg::FieldWidth-1:0]   power
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_WAIT
    } state_t;

    state_t                              state_reg;
    logic                                done_reg;
    logic                                launch_reg;
    logic [modexp_pkg::FieldWidth-1:0]   power_reg;
    logic [modexp_pkg::FieldWidth-1:0]   sq_reg;
    logic [modexp_pkg::FieldWidth-1:0]   acc_reg;
    logic [modexp_pkg::FieldWidth-1:0]   exp_reg;
    logic [modexp_pkg::FieldWidth-1:0]   base_red;

    logic                                sq_done;
    logic                                acc_done;
    logic [modexp_pkg::FieldWidth-1:0]   sq_prod;
    logic [modexp_pkg::FieldWidth-1:0]   acc_prod;

    // base < 2*Prime, so one subtract reduces it
    assign base_red = (base >= modexp_pkg::Prime) ? base - modexp_pkg::Prime : base;

    modexp_mulmod u_square (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (launch_reg),
        .a      (sq_reg),
        .b      (sq_reg),
        .done   (sq_done),
        .result (sq_prod)
    );

    modexp_mulmod u_accum (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (launch_reg),
        .a      (acc_reg),
        .b      (sq_reg),
        .done   (acc_done),
        .result (acc_prod)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done_reg   <= 1'b0;
            launch_reg <= 1'b0;
        end
        else
        begin
            done_reg   <= 1'b0;
            launch_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (exp_reg == '0)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        launch_reg <= 1'b1;
                        state_reg  <= S_WAIT;
                    end
                end
                S_WAIT:
                begin
                    if (sq_done)
                    begin
                        state_reg <= S_CHECK;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            sq_reg  <= base_red;
            exp_reg <= exponent;
            acc_reg <= modexp_pkg::One;
        end
        else if (state_reg == S_WAIT && sq_done)
        begin
            // advance one exponent bit; keep acc when the bit is clear
            sq_reg  <= sq_prod;
            exp_reg <= {1'b0, exp_reg[modexp_pkg::FieldWidth-1:1]};
            if (exp_reg[0])
            begin
                acc_reg <= acc_prod;
            end
        end
        if (state_reg == S_CHECK && exp_reg == '0)
        begin
            power_reg <= acc_reg;
        end
    end

    assign busy  = (state_reg != S_IDLE);
    assign done  = done_reg;
    assign power = power_reg;

`ifndef SYNTH
    a_units_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        sq_done == acc_done)
        else $error("multipliers out of step");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE && power_reg < modexp_pkg::Prime))
        else $error("result shown while busy or unreduced");
    a_launch_waits: assert property (@(posedge clk) disable iff (!rst_n)
        launch_reg |-> (state_reg == S_WAIT && exp_reg != '0))
        else $error("launch outside wait");
    a_done_only_wait: assert property (@(posedge clk) disable iff (!rst_n)
        sq_done |-> (state_reg == S_WAIT))
        else $error("multiplier finished outside wait");
`endif

endmodule
